// File: hw/rtl/graph_traversal_hop_distance_macros.svh
// Assertion macros shared by the graph traversal RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef GRAPH_TRAVERSAL_HOP_DISTANCE_MACROS_SVH
`define GRAPH_TRAVERSAL_HOP_DISTANCE_MACROS_SVH
// Implication checked every clock, masked in reset.
`define GTHD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, masked in reset.
`define GTHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: hw/rtl/gthd_pkg.sv
// Shared types and constants for the graph traversal block.
// Depends on nothing.
package gthd_pkg;
  localparam int MaxNodes = 64;
  localparam int MaxEdges = 256;
  localparam int NodeW = $clog2(MaxNodes);
  localparam int EdgeW = $clog2(MaxEdges);
  localparam int PtrW = EdgeW + 1;
  localparam int HopW = 7;
  localparam logic [HopW-1:0] HopUnvisited = '1;
  localparam logic [PtrW-1:0] EdgeNull = PtrW'(MaxEdges);

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpTraverse = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic [1:0] StVisit = 2'd0;
  localparam logic [1:0] StOk = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StBad = 2'd3;

  localparam logic [1:0] RegNodeCount = 2'd0;
  localparam logic [1:0] RegMode = 2'd1;
  localparam logic [1:0] RegUndirected = 2'd2;

  typedef struct packed {
    logic [NodeW-1:0] node_id;
    logic [5:0] hop_distance;
    logic last;
    logic [1:0] status;
  } result_t;
endpackage

// File: hw/rtl/graph_traversal_hop_distance.sv
// Graph traversal (breadth-first / depth-first) with hop distance records.
// Sequencing, with no output stall: an add edge stores one direction in directed mode and
// both undirected (each stored direction is a registered read of the list tail, a link
// write into the old tail entry and a fresh entry write); a clear or a rejected item goes
// straight to the output, since list heads and hop marks carry per-node valid bits and
// need no sweep. A traverse runs accept and setup, then for each node popped a pop,
// frontier read, head read and end-of-list check, for each adjacency entry scanned a
// read, wait and check, for each discovered node a record release and reload, and a
// final pop and output; the single sequencer steps the edge store read port one entry at
// a time, so the walk sets the rate. m_tready low while a record waits stalls the walk.
// One status record (status 1, 2 or 3, last set) comes back per add, clear or rejected item;
// a traverse returns one visit record per discovered node in discovery order, the last one
// flagged. The input is not ready while an item is in work or its result waits in the
// output register. Write configuration only while idle; a write takes effect at once.
// Depends on gthd_pkg, gthd_edge_store and the assertion macro header.
`include "graph_traversal_hop_distance_macros.svh"
module graph_traversal_hop_distance (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [15:0] s_tdata,  // [1:0] operation, [7:2] node_a, [13:8] node_b
  output logic m_tvalid,
  input  logic m_tready,
  output logic [15:0] m_tdata,  // [5:0] node_id, [11:6] hop_distance
  output logic m_tlast,
  output logic [1:0] m_tuser,   // status
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);
  localparam int NW = gthd_pkg::NodeW;
  localparam int EW = gthd_pkg::EdgeW;
  localparam int PW = gthd_pkg::PtrW;
  localparam int HW = gthd_pkg::HopW;
  localparam int NN = gthd_pkg::MaxNodes;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_RD, S_ADD_LK, S_ADD_WR, S_TR_INIT, S_POP, S_POP_WAIT, S_HEAD,
    S_EDGE_RD, S_EDGE_WAIT, S_EDGE_CHK, S_EMIT, S_OUT
  } state_t;

  state_t state;
  logic [6:0] node_count;
  logic mode, undirected;
  logic [PW-1:0] edge_fill;
  logic [PW-1:0] list_head [gthd_pkg::MaxNodes];
  logic [PW-1:0] list_tail [gthd_pkg::MaxNodes];
  logic [gthd_pkg::MaxNodes-1:0] list_valid;
  logic [HW-1:0] hop_mark [gthd_pkg::MaxNodes];
  logic [gthd_pkg::MaxNodes-1:0] hop_valid;
  logic [NW-1:0] frontier [gthd_pkg::MaxNodes];
  logic [NW:0] front_rd, front_wr;

  logic [NW-1:0] node_a, node_b, src, dst, cur;
  logic second;
  logic [PW-1:0] edge_ptr;
  logic [HW-1:0] cur_hop;
  gthd_pkg::result_t res;
  logic [NW-1:0] fr_rdata;
  logic [PW-1:0] tail_q, head_q;
  logic [HW-1:0] hop_q;

  // edge store ports
  logic es_wr, es_lk;
  logic [EW-1:0] es_waddr, es_laddr, es_raddr;
  logic [PW-1:0] es_lnext;
  logic [NW-1:0] es_target;
  logic [PW-1:0] es_next;

  function automatic gthd_pkg::result_t status_rec(logic [1:0] code);
    return '{node_id: '0, hop_distance: '0, last: 1'b1, status: code};
  endfunction

  gthd_edge_store u_store (
    .clk(clk), .wr_en(es_wr), .wr_addr(es_waddr), .wr_target(dst),
    .wr_next(gthd_pkg::EdgeNull), .lk_en(es_lk), .lk_addr(es_laddr), .lk_next(es_lnext),
    .rd_addr(es_raddr), .rd_target(es_target), .rd_next(es_next)
  );

  logic [6:0] lim;
  assign lim = (node_count > 7'(gthd_pkg::MaxNodes)) ? 7'(gthd_pkg::MaxNodes) : node_count;

  // link the old tail to the new entry first, then write the entry itself
  assign es_wr = (state == S_ADD_WR);
  assign es_waddr = edge_fill[EW-1:0];
  assign es_lk = (state == S_ADD_LK) && list_valid[src];
  assign es_laddr = tail_q[EW-1:0];
  assign es_lnext = edge_fill;
  assign es_raddr = edge_ptr[EW-1:0];

  logic [1:0] op;
  assign op = s_tdata[1:0];
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {4'd0, res.hop_distance, res.node_id};
  assign m_tlast = res.last;
  assign m_tuser = res.status;

  logic [PW-1:0] need;
  assign need = undirected ? PW'(2) : PW'(1);

  // frontier memory read, registered
  always_ff @(posedge clk) begin
    fr_rdata <= frontier[mode ? NW'(front_wr - 1'b1) : front_rd[NW-1:0]];
  end

  // per-node table reads, registered: tail of the list being extended, head and
  // hop count of the node just popped
  always_ff @(posedge clk) begin
    tail_q <= list_tail[src];
    head_q <= list_head[fr_rdata];
    hop_q <= hop_mark[fr_rdata];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 7'd64;
      mode <= 1'b0;
      undirected <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gthd_pkg::RegNodeCount: node_count <= cfg_data;
        gthd_pkg::RegMode: mode <= cfg_data[0];
        gthd_pkg::RegUndirected: undirected <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      edge_fill <= '0;
      list_valid <= '0;
      hop_valid <= '0;
      front_rd <= '0;
      front_wr <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          node_a <= s_tdata[7:2];
          node_b <= s_tdata[13:8];
          priority if (op == gthd_pkg::OpAdd) begin
            if ({1'b0, s_tdata[7:2]} >= lim || {1'b0, s_tdata[13:8]} >= lim) begin
              res <= status_rec(gthd_pkg::StBad);
              state <= S_OUT;
            end else if (PW'(gthd_pkg::MaxEdges) - edge_fill < need) begin
              res <= status_rec(gthd_pkg::StFull);
              state <= S_OUT;
            end else begin
              res <= status_rec(gthd_pkg::StOk);
              src <= s_tdata[7:2];
              dst <= s_tdata[13:8];
              second <= 1'b0;
              state <= S_ADD_RD;
            end
          end else if (op == gthd_pkg::OpTraverse) begin
            if ({1'b0, s_tdata[7:2]} >= lim) begin
              res <= status_rec(gthd_pkg::StBad);
              state <= S_OUT;
            end else state <= S_TR_INIT;
          end else if (op == gthd_pkg::OpClear) begin
            list_valid <= '0;
            hop_valid <= '0;
            edge_fill <= '0;
            res <= status_rec(gthd_pkg::StOk);
            state <= S_OUT;
          end else begin
            res <= status_rec(gthd_pkg::StBad);
            state <= S_OUT;
          end
        end
        S_ADD_RD: state <= S_ADD_LK;
        S_ADD_LK: state <= S_ADD_WR;
        S_ADD_WR: begin
          if (!list_valid[src]) list_head[src] <= edge_fill;
          list_tail[src] <= edge_fill;
          list_valid[src] <= 1'b1;
          edge_fill <= edge_fill + 1'b1;
          if (undirected && !second) begin
            second <= 1'b1;
            src <= node_b;
            dst <= node_a;
            state <= S_ADD_RD;
          end else state <= S_OUT;
        end
        S_TR_INIT: begin
          hop_valid <= NN'(1) << node_a;
          hop_mark[node_a] <= '0;
          frontier[0] <= node_a;
          front_rd <= '0;
          front_wr <= (NW+1)'(1);
          res <= '{node_id: node_a, hop_distance: '0, last: 1'b0,
                   status: gthd_pkg::StVisit};
          state <= S_POP;
        end
        // the pending record is the previous discovery; released once the next is known
        S_POP: begin
          if (front_wr == front_rd || (mode && front_wr == '0)) begin
            res.last <= 1'b1;
            front_rd <= '0;
            front_wr <= '0;
            state <= S_OUT;
          end else state <= S_POP_WAIT;
        end
        S_POP_WAIT: begin
          cur <= fr_rdata;
          if (mode) front_wr <= front_wr - 1'b1;
          else front_rd <= front_rd + 1'b1;
          state <= S_HEAD;
        end
        S_HEAD: begin
          cur_hop <= hop_q;
          edge_ptr <= list_valid[cur] ? head_q : gthd_pkg::EdgeNull;
          state <= S_EDGE_RD;
        end
        S_EDGE_RD: begin
          if (edge_ptr >= gthd_pkg::EdgeNull || edge_ptr >= edge_fill) begin
            if (!mode && front_rd == front_wr) begin
              front_rd <= '0;
              front_wr <= '0;
            end
            state <= S_POP;
          end else state <= S_EDGE_WAIT;
        end
        S_EDGE_WAIT: state <= S_EDGE_CHK;
        S_EDGE_CHK: begin
          edge_ptr <= es_next;
          if ({1'b0, es_target} < lim && !hop_valid[es_target] &&
              front_wr < (NW+1)'(gthd_pkg::MaxNodes)) begin
            hop_valid[es_target] <= 1'b1;
            hop_mark[es_target] <= cur_hop + 1'b1;
            frontier[front_wr[NW-1:0]] <= es_target;
            front_wr <= front_wr + 1'b1;
            dst <= es_target;
            state <= S_OUT;
          end else state <= S_EDGE_RD;
        end
        S_EMIT: begin
          res <= '{node_id: dst, hop_distance: 6'(cur_hop + 1'b1), last: 1'b0,
                   status: gthd_pkg::StVisit};
          state <= S_EDGE_RD;
        end
        S_OUT: if (m_tready) begin
          // visit records other than the final one resume the walk
          if (res.status == gthd_pkg::StVisit && !res.last) state <= S_EMIT;
          else state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GTHD_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, edge_fill <= PW'(gthd_pkg::MaxEdges),
    "edge fill beyond store")
  `GTHD_ASSERT_IMP(a_ready_idle, clk, rst, s_tready, !m_tvalid,
    "input ready while result pending")
  `GTHD_ASSERT_NEXT(a_accept_busy, clk, rst, s_tvalid && s_tready, !s_tready,
    "ready held after accept")
endmodule

// File: hw/rtl/gthd_edge_store.sv
// Adjacency store: edge target and next-link memories, one entry write port, one tail link port and one read port.
// Depends on gthd_pkg.
module gthd_edge_store (
  input  logic clk,
  input  logic wr_en,
  input  logic [gthd_pkg::EdgeW-1:0] wr_addr,
  input  logic [gthd_pkg::NodeW-1:0] wr_target,
  input  logic [gthd_pkg::PtrW-1:0] wr_next,
  input  logic lk_en,
  input  logic [gthd_pkg::EdgeW-1:0] lk_addr,
  input  logic [gthd_pkg::PtrW-1:0] lk_next,
  input  logic [gthd_pkg::EdgeW-1:0] rd_addr,
  output logic [gthd_pkg::NodeW-1:0] rd_target,
  output logic [gthd_pkg::PtrW-1:0] rd_next
);
  logic [gthd_pkg::NodeW-1:0] tgt_mem [gthd_pkg::MaxEdges];
  logic [gthd_pkg::PtrW-1:0] nxt_mem [gthd_pkg::MaxEdges];

  always_ff @(posedge clk) begin
    if (wr_en) tgt_mem[wr_addr] <= wr_target;
    rd_target <= tgt_mem[rd_addr];
  end

  // next-link memory: one write per cycle, either a fresh entry or a tail link
  always_ff @(posedge clk) begin
    if (wr_en) nxt_mem[wr_addr] <= wr_next;
    else if (lk_en) nxt_mem[lk_addr] <= lk_next;
    rd_next <= nxt_mem[rd_addr];
  end
endmodule
